// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define RVP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked at every edge, reset included
`define RVP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/rvp_pkg.sv =====
package rvp_pkg;

   localparam int VALUE_W     = 32;
   localparam int PAIR_W      = 15;
   localparam int MAX_LEN_DEF = 256;

   localparam logic [PAIR_W-1:0] PAIR_MAX = {PAIR_W{1'b1}};

   // control bits of a token moving down the cell row
   typedef struct packed {
      logic valid;
      logic last;
      logic ovf;
   } rvp_ctl_type;

endpackage

// ===== rtl/rvp_chan_if.sv =====
// input beat: one sequence element
interface rvp_req_if import rvp_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;
   logic                      last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

// result beat: pair count of one sequence
interface rvp_rsp_if import rvp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [PAIR_W-1:0] pair_count;
   logic              overflow;

   modport source (output valid, output pair_count, output overflow, input ready);
   modport sink   (input valid, input pair_count, input overflow, output ready);
endinterface

// ===== rtl/rvp_cell.sv =====
module rvp_cell import rvp_pkg::*; #(
   parameter int MAX_LEN  = MAX_LEN_DEF,
   parameter int CELL_IDX = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  rvp_ctl_type             up_ctl,
   input  logic [$clog2(MAX_LEN)-1:0] up_idx,
   input  logic signed [VALUE_W:0] up_twice,
   input  logic [$clog2(MAX_LEN)-1:0] up_hits,
   output rvp_ctl_type             dn_ctl,
   output logic [$clog2(MAX_LEN)-1:0] dn_idx,
   output logic signed [VALUE_W:0] dn_twice,
   output logic [$clog2(MAX_LEN)-1:0] dn_hits
);

   localparam int IDX_W = $clog2(MAX_LEN);
   localparam int HIT_W = $clog2(MAX_LEN);

   rvp_ctl_type               ctl_ff;
   logic [IDX_W-1:0]          idx_ff;
   logic signed [VALUE_W:0]   twice_ff;
   logic [HIT_W-1:0]          hits_ff;
   logic [HIT_W-1:0]          hits_in;
   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W:0]   value_ext;
   logic                      live;
   logic                      hit;
   logic                      store;

   // compare against the element held here, or take the element as ours
   assign live      = up_ctl.valid && !up_ctl.ovf;
   assign value_ext = {value_ff[VALUE_W-1], value_ff};
   assign hit       = live && (up_idx > IDX_W'(CELL_IDX)) && (value_ext > up_twice);
   assign store     = live && (up_idx == IDX_W'(CELL_IDX));
   assign hits_in   = up_hits + HIT_W'(hit);

   // token control
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= up_ctl;
      end
   end

   // token payload and stored element
   always_ff @(posedge clock) begin
      if (adv) begin
         idx_ff   <= up_idx;
         twice_ff <= up_twice;
         hits_ff  <= hits_in;
         if (store) begin
            value_ff <= up_twice[VALUE_W:1];
         end
      end
   end

   assign dn_ctl   = ctl_ff;
   assign dn_idx   = idx_ff;
   assign dn_twice = twice_ff;
   assign dn_hits  = hits_ff;

endmodule

// ===== rtl/rvp_tail.sv =====
module rvp_tail import rvp_pkg::*; #(
   parameter int MAX_LEN = MAX_LEN_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  rvp_ctl_type                tok_ctl,
   input  logic [$clog2(MAX_LEN)-1:0] tok_hits,
   output logic                       adv,
   rvp_rsp_if.source                  rsp_chan
);

   localparam int SUM_W = PAIR_W + 1;

   logic [PAIR_W-1:0] acc_ff;
   logic [PAIR_W-1:0] acc_in;
   logic              ovf_ff;
   logic              ovf_in;
   logic              rsp_valid_ff;
   logic [PAIR_W-1:0] rsp_count_ff;
   logic              rsp_ovf_ff;
   logic [SUM_W-1:0]  sum;
   logic [PAIR_W-1:0] sat;

   // the whole row moves whenever the result slot can take a beat
   assign adv = !rsp_valid_ff || rsp_chan.ready;

   // saturating sum of per-element hits
   assign sum    = SUM_W'(acc_ff) + SUM_W'(tok_hits);
   assign sat    = sum[PAIR_W] ? PAIR_MAX : sum[PAIR_W-1:0];
   assign ovf_in = ovf_ff || tok_ctl.ovf;
   assign acc_in = tok_ctl.last ? '0 : sat;

   // per-sequence accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (adv && tok_ctl.valid) begin
         acc_ff <= acc_in;
         ovf_ff <= tok_ctl.last ? 1'b0 : ovf_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= tok_ctl.valid && tok_ctl.last;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && tok_ctl.valid && tok_ctl.last) begin
         rsp_count_ff <= sat;
         rsp_ovf_ff   <= ovf_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.pair_count = rsp_count_ff;
   assign rsp_chan.overflow   = rsp_ovf_ff;

endmodule

// ===== rtl/reverse_pair_counter_top.sv =====
// a last beat passes the cell registers, then the result register, to become a result beat
// throughput: one input beat per cycle unless halted, set by the MAX_LEN cells in lockstep
// the row halts as a whole while a result beat waits in the output register
// reset (synchronous) clears the element counter, token valid bits and accumulator
// stored elements are not cleared; each is written before any later element reads it
`include "assert_macros.svh"

module reverse_pair_counter_top import rvp_pkg::*; #(
   parameter int MAX_LEN = MAX_LEN_DEF
) (
   input  logic      clock,
   input  logic      reset,
   rvp_req_if.sink   req_chan,
   rvp_rsp_if.source rsp_chan
);

   localparam int IDX_W = $clog2(MAX_LEN);
   localparam int CNT_W = $clog2(MAX_LEN + 1);

   logic              adv;
   logic              accept;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              full;

   rvp_ctl_type             ctl   [MAX_LEN+1];
   logic [IDX_W-1:0]        idx   [MAX_LEN+1];
   logic signed [VALUE_W:0] twice [MAX_LEN+1];
   logic [IDX_W-1:0]        hits  [MAX_LEN+1];

   assign req_chan.ready = adv;
   assign accept         = req_chan.valid && adv;

   // element counter of the open sequence
   assign full = (count_ff == CNT_W'(MAX_LEN));

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (req_chan.last) begin
            count_in = '0;
         end else if (!full) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // token entering the row
   assign ctl[0]   = '{valid: accept, last: req_chan.last, ovf: full};
   assign idx[0]   = count_ff[IDX_W-1:0];
   assign twice[0] = {req_chan.value, 1'b0};
   assign hits[0]  = '0;

   // row of compare cells
   for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
      rvp_cell #(
         .MAX_LEN  (MAX_LEN),
         .CELL_IDX (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .up_ctl   (ctl[k]),
         .up_idx   (idx[k]),
         .up_twice (twice[k]),
         .up_hits  (hits[k]),
         .dn_ctl   (ctl[k+1]),
         .dn_idx   (idx[k+1]),
         .dn_twice (twice[k+1]),
         .dn_hits  (hits[k+1])
      );
   end

   // count accumulation and result register
   rvp_tail #(
      .MAX_LEN (MAX_LEN)
   ) u_tail (
      .clock    (clock),
      .reset    (reset),
      .tok_ctl  (ctl[MAX_LEN]),
      .tok_hits (hits[MAX_LEN]),
      .adv      (adv),
      .rsp_chan (rsp_chan)
   );

   // checks
   `RVP_ASSERT(a_stall_blocks_input, (rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready, "input taken while result stalled")
   `RVP_ASSERT(a_count_bounded, count_ff <= CNT_W'(MAX_LEN), "element counter beyond limit")
   `RVP_ASSERT(a_last_clears, (accept && req_chan.last) |=> (count_ff == '0), "counter not cleared after last beat")
   `RVP_ASSERT_ALWAYS(a_reset_no_rsp, reset |=> !rsp_chan.valid, "result valid right after reset")

endmodule
